// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BDC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define BDC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- src/bdc_pkg.sv -----
// shared types, codes and sizes of the button debounce and click classifier
package bdc_pkg;

    localparam int BUTTON_COUNT     = 3;
    localparam int TICK_COUNT_WIDTH = 16;
    localparam int RESULT_LIMIT     = 3;
    localparam int QUEUE_DEPTH      = 2;

    localparam int SLOT_IDX_W = $clog2(RESULT_LIMIT);
    localparam int SLOT_CNT_W = $clog2(RESULT_LIMIT + 1);
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DEB_W      = 4;
    localparam int THR_W      = 16;
    localparam int BTN_ID_W   = 2;
    localparam int KIND_W     = 3;
    localparam int HOLD_W     = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_SAMPLES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_CLICK_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SHORT_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LONG_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ABORT_TICKS      = 3'd4;

    localparam logic [DEB_W-1:0] RST_DEBOUNCE_SAMPLES = 4'd4;
    localparam logic [THR_W-1:0] RST_LONG_CLICK_TICKS = 16'd50;
    localparam logic [THR_W-1:0] RST_HOLD_SHORT_TICKS = 16'd200;
    localparam logic [THR_W-1:0] RST_HOLD_LONG_TICKS  = 16'd1000;
    localparam logic [THR_W-1:0] RST_ABORT_TICKS      = 16'd3000;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_SHORT         = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LONG          = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HOLD_RELEASED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HOLD_FIRST    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HOLD_SECOND   = 3'd4;

    // hold progress per button
    localparam logic [HOLD_W-1:0] HOLD_NONE   = 2'd0;
    localparam logic [HOLD_W-1:0] HOLD_FIRST  = 2'd1;
    localparam logic [HOLD_W-1:0] HOLD_SECOND = 2'd2;

    typedef struct packed {
        logic command;
        logic local_pressed;
        logic remote_button;
        logic remote_pressed;
    } t_in_item;

    typedef struct packed {
        logic [BTN_ID_W-1:0] button_id;
        logic [KIND_W-1:0]   event_kind;
        logic                last_event;
    } t_out_item;

    // all events caused by one input item, last one flagged
    typedef t_out_item [RESULT_LIMIT-1:0] t_rec;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// ----- src/bdc_front.sv -----
// front end: config registers, debounce, per-button press state and event building
module bdc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bdc_pkg::t_cfg_wr i_cfg,
    input  logic             i_valid,
    input  bdc_pkg::t_in_item i_item,
    output logic             o_stall,
    input  logic             i_full,
    output logic             o_push,
    output bdc_pkg::t_rec    o_rec
);

    logic [bdc_pkg::DEB_W-1:0] r_cfg_ds;
    logic [bdc_pkg::THR_W-1:0] r_cfg_lc;
    logic [bdc_pkg::THR_W-1:0] r_cfg_hs;
    logic [bdc_pkg::THR_W-1:0] r_cfg_hl;
    logic [bdc_pkg::THR_W-1:0] r_cfg_ab;

    logic [bdc_pkg::DEB_W-1:0] r_db_cnt, n_db_cnt;
    logic                      r_stable, n_stable;
    logic [bdc_pkg::BUTTON_COUNT-1:0] r_level, n_level;
    logic [bdc_pkg::BUTTON_COUNT-1:0] r_active, n_active;
    logic [bdc_pkg::HOLD_W-1:0] r_hold [bdc_pkg::BUTTON_COUNT];
    logic [bdc_pkg::HOLD_W-1:0] n_hold [bdc_pkg::BUTTON_COUNT];
    logic [bdc_pkg::TICK_COUNT_WIDTH-1:0] r_ticks [bdc_pkg::BUTTON_COUNT];
    logic [bdc_pkg::TICK_COUNT_WIDTH-1:0] n_ticks [bdc_pkg::BUTTON_COUNT];

    logic                           accept;
    logic [bdc_pkg::SLOT_CNT_W-1:0] ev_count;
    bdc_pkg::t_rec                  rec;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        logic [bdc_pkg::DEB_W-1:0]            v_cnt;
        logic [bdc_pkg::TICK_COUNT_WIDTH-1:0] v_t;
        logic [bdc_pkg::BUTTON_COUNT-1:0]     v_ev;
        logic [bdc_pkg::KIND_W-1:0]           v_kind [bdc_pkg::BUTTON_COUNT];
        logic [bdc_pkg::SLOT_CNT_W-1:0]       v_n;

        n_db_cnt = r_db_cnt;
        n_stable = r_stable;
        n_level  = r_level;
        n_active = r_active;
        n_hold   = r_hold;
        n_ticks  = r_ticks;
        v_cnt    = '0;
        v_t      = '0;
        v_ev     = '0;
        v_n      = '0;
        rec      = '0;

        if (!i_item.command) begin
            for (int b = 0; b < bdc_pkg::BUTTON_COUNT; b++) begin
                if (r_active[b] && !(&r_ticks[b])) begin
                    n_ticks[b] = r_ticks[b] + 1'b1;
                end
            end
            // a bounce back to the stable level leaves the count as it is
            if (i_item.local_pressed != r_stable) begin
                if (r_db_cnt == '0) begin
                    n_db_cnt = bdc_pkg::DEB_W'(1);
                end else begin
                    v_cnt = r_db_cnt + 1'b1;
                    if (v_cnt >= r_cfg_ds) begin
                        n_stable   = i_item.local_pressed;
                        n_level[0] = i_item.local_pressed;
                        n_db_cnt   = '0;
                    end else begin
                        n_db_cnt = v_cnt;
                    end
                end
            end
        end else begin
            for (int b = 0; b < bdc_pkg::BUTTON_COUNT; b++) begin
                if (b == int'(i_item.remote_button) + 1) begin
                    n_level[b] = i_item.remote_pressed;
                end
            end
        end

        for (int b = 0; b < bdc_pkg::BUTTON_COUNT; b++) begin
            v_t       = n_ticks[b];
            v_kind[b] = bdc_pkg::KIND_SHORT;
            if (n_level[b] && n_active[b]) begin
                // at most one hold step per evaluation
                case (n_hold[b])
                    bdc_pkg::HOLD_NONE: begin
                        if (v_t >= r_cfg_hs) begin
                            v_ev[b]   = 1'b1;
                            v_kind[b] = bdc_pkg::KIND_HOLD_FIRST;
                            n_hold[b] = bdc_pkg::HOLD_FIRST;
                        end
                    end
                    bdc_pkg::HOLD_FIRST: begin
                        if (v_t >= r_cfg_hl) begin
                            v_ev[b]   = 1'b1;
                            v_kind[b] = bdc_pkg::KIND_HOLD_SECOND;
                            n_hold[b] = bdc_pkg::HOLD_SECOND;
                        end
                    end
                    default: begin
                        // abort drops the press without an event
                        if (v_t >= r_cfg_ab) begin
                            n_level[b]  = 1'b0;
                            n_active[b] = 1'b0;
                        end
                    end
                endcase
            end
            if (!n_level[b] && n_active[b]) begin
                v_ev[b] = 1'b1;
                if (v_t < r_cfg_lc) begin
                    v_kind[b] = bdc_pkg::KIND_SHORT;
                end else if (v_t < r_cfg_hs) begin
                    v_kind[b] = bdc_pkg::KIND_LONG;
                end else begin
                    v_kind[b] = bdc_pkg::KIND_HOLD_RELEASED;
                end
                n_active[b] = 1'b0;
            end
            if (n_level[b] && !n_active[b]) begin
                n_active[b] = 1'b1;
                n_ticks[b]  = '0;
                n_hold[b]   = bdc_pkg::HOLD_NONE;
            end
        end

        // pack events into slots in button order
        for (int b = 0; b < bdc_pkg::BUTTON_COUNT; b++) begin
            if (v_ev[b] && v_n < bdc_pkg::SLOT_CNT_W'(bdc_pkg::RESULT_LIMIT)) begin
                rec[v_n[bdc_pkg::SLOT_IDX_W-1:0]].button_id  = bdc_pkg::BTN_ID_W'(b);
                rec[v_n[bdc_pkg::SLOT_IDX_W-1:0]].event_kind = v_kind[b];
                v_n = v_n + 1'b1;
            end
        end
        for (int s = 0; s < bdc_pkg::RESULT_LIMIT; s++) begin
            rec[s].last_event = (bdc_pkg::SLOT_CNT_W'(s) + 1'b1 == v_n);
        end
        ev_count = v_n;
    end

    assign o_push = accept && (ev_count != '0);
    assign o_rec  = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ds <= bdc_pkg::RST_DEBOUNCE_SAMPLES;
            r_cfg_lc <= bdc_pkg::RST_LONG_CLICK_TICKS;
            r_cfg_hs <= bdc_pkg::RST_HOLD_SHORT_TICKS;
            r_cfg_hl <= bdc_pkg::RST_HOLD_LONG_TICKS;
            r_cfg_ab <= bdc_pkg::RST_ABORT_TICKS;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                bdc_pkg::REG_DEBOUNCE_SAMPLES: r_cfg_ds <= i_cfg.data[bdc_pkg::DEB_W-1:0];
                bdc_pkg::REG_LONG_CLICK_TICKS: r_cfg_lc <= i_cfg.data[bdc_pkg::THR_W-1:0];
                bdc_pkg::REG_HOLD_SHORT_TICKS: r_cfg_hs <= i_cfg.data[bdc_pkg::THR_W-1:0];
                bdc_pkg::REG_HOLD_LONG_TICKS:  r_cfg_hl <= i_cfg.data[bdc_pkg::THR_W-1:0];
                bdc_pkg::REG_ABORT_TICKS:      r_cfg_ab <= i_cfg.data[bdc_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db_cnt <= '0;
            r_stable <= 1'b0;
            r_level  <= '0;
            r_active <= '0;
            for (int b = 0; b < bdc_pkg::BUTTON_COUNT; b++) begin
                r_hold[b]  <= bdc_pkg::HOLD_NONE;
                r_ticks[b] <= '0;
            end
        end else if (accept) begin
            r_db_cnt <= n_db_cnt;
            r_stable <= n_stable;
            r_level  <= n_level;
            r_active <= n_active;
            r_hold   <= n_hold;
            r_ticks  <= n_ticks;
        end
    end

endmodule

// ----- src/bdc_queue.sv -----
// short queue of per-item event records between front and back
module bdc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bdc_pkg::t_rec i_rec,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_avail,
    output bdc_pkg::t_rec o_rec
);

    localparam logic [bdc_pkg::QPTR_W-1:0] PTR_LAST = bdc_pkg::QPTR_W'(bdc_pkg::QUEUE_DEPTH - 1);

    bdc_pkg::t_rec               r_mem [bdc_pkg::QUEUE_DEPTH];
    logic [bdc_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [bdc_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [bdc_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == bdc_pkg::QCNT_W'(bdc_pkg::QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// ----- src/bdc_back.sv -----
// back end: unpacks one record into result beats through the output register
module bdc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  bdc_pkg::t_rec     i_rec,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output bdc_pkg::t_out_item o_data
);

    logic                           r_busy;
    logic [bdc_pkg::SLOT_IDX_W-1:0] r_idx;
    bdc_pkg::t_rec                  r_rec;
    logic                           done;
    logic                           load;

    assign o_valid = r_busy;
    assign o_data  = r_rec[r_idx];
    assign done    = r_busy && !i_stall && r_rec[r_idx].last_event;
    // next record moves up in the cycle the last beat leaves
    assign load    = i_avail && (!r_busy || done);
    assign o_pop   = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (r_busy && !i_stall) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

// ----- src/button_debounce_click_classifier_unit.sv -----
// top level of the button debounce and click classifier
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (bdc_pkg::t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (bdc_pkg::t_out_item)
//  cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// an input item is taken every cycle while the record queue has room; its state update
// and event building finish in the cycle it is taken
// the output register sends one event per cycle while i_out_stall is low
// the two-entry record queue fills when the output is stalled, and o_in_stall follows it
// reset is synchronous; there is no clearing pass
module button_debounce_click_classifier_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bdc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bdc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [bdc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bdc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    bdc_pkg::t_cfg_wr cfg;
    logic             q_full;
    logic             q_push;
    logic             q_avail;
    logic             q_pop;
    bdc_pkg::t_rec    front_rec;
    bdc_pkg::t_rec    queue_rec;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    bdc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_stall (o_in_stall),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_rec   (front_rec)
    );

    bdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_rec   (queue_rec)
    );

    bdc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_avail),
        .i_rec   (queue_rec),
        .o_pop   (q_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

// ----- src/bdc_checker.sv -----
// port-level checks on the classifier, bound to the top level
`include "assert_macros.svh"

module bdc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input bdc_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bdc_pkg::t_out_item o_out_data
);

    logic in_held;
    logic out_held;
    logic out_mid_item;
    logic out_codes_ok;

    assign in_held      = i_in_valid && o_in_stall;
    assign out_held     = o_out_valid && i_out_stall;
    assign out_mid_item = o_out_valid && !i_out_stall && !o_out_data.last_event;
    assign out_codes_ok =
        (o_out_data.button_id < bdc_pkg::BTN_ID_W'(bdc_pkg::BUTTON_COUNT)) &&
        (o_out_data.event_kind <= bdc_pkg::KIND_HOLD_SECOND);

    // a stalled result beat holds
    `BDC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_data))

    // only defined buttons and kinds leave the block
    `BDC_ASSERT_IMP(a_out_codes, i_clk, i_rst_n, o_out_valid, out_codes_ok)

    // events of one item leave without gaps
    `BDC_ASSERT_NXT(a_item_burst, i_clk, i_rst_n, out_mid_item, o_out_valid)

    // input only backs up behind a waiting result
    `BDC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid)

    // a stalled input beat holds
    `BDC_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, in_held, i_in_valid && $stable(i_in_data))

endmodule

bind button_debounce_click_classifier_unit bdc_checker u_bdc_checker (.*);
